// ----- hdl/rdd_pkg.sv -----
package rdd_pkg;

    localparam int INPUT_WIDTH_DEFAULT = 16;
    localparam int RADIX_WIDTH         = 4;
    localparam int DIGIT_WIDTH         = 4;
    localparam int DIGITS_WIDTH        = 50;
    localparam int EXP_WIDTH           = 4;

    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 4'd8;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 4'd10;

    // one-hot phase strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic emit;
    } rdd_ctrl_t;

    // out-of-range radix codes clamp to the nearest legal base
    function automatic logic [RADIX_WIDTH-1:0] effective_radix(
        input logic [RADIX_WIDTH-1:0] radix
    );
        logic [RADIX_WIDTH-1:0] result;
        if (radix < RADIX_MIN)
        begin
            result = RADIX_MIN;
        end
        else if (radix > RADIX_MAX)
        begin
            result = RADIX_MAX;
        end
        else
        begin
            result = radix;
        end
        return result;
    endfunction

endpackage

// ----- hdl/rdd_value_if.sv -----
interface rdd_value_if #(
    parameter int WIDTH = rdd_pkg::INPUT_WIDTH_DEFAULT
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hdl/rdd_result_if.sv -----
interface rdd_result_if;
    logic                               valid;
    logic                               ready;
    logic [rdd_pkg::DIGITS_WIDTH-1:0]   digits_as_decimal;
    logic [rdd_pkg::EXP_WIDTH-1:0]      top_exponent;

    modport source (output valid, output digits_as_decimal, output top_exponent, input ready);
    modport sink   (input valid, input digits_as_decimal, input top_exponent, output ready);
endinterface

// ----- hdl/rdd_cfg_if.sv -----
interface rdd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rdd_pkg::RADIX_WIDTH-1:0]   radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// ----- hdl/rdd_digit_shifter.sv -----
module rdd_digit_shifter #(
    parameter int INPUT_WIDTH = rdd_pkg::INPUT_WIDTH_DEFAULT
) (
    input  logic                             clk,
    input  rdd_pkg::rdd_ctrl_t               ctrl,
    input  logic [rdd_pkg::RADIX_WIDTH-1:0]  radix,
    input  logic [INPUT_WIDTH-1:0]           value,
    output logic [rdd_pkg::DIGIT_WIDTH-1:0]  top_digit
);
    import rdd_pkg::*;

    // enough radix digits for the widest value in base two
    localparam int NDIG = INPUT_WIDTH;

    logic [INPUT_WIDTH-1:0] value_reg;
    logic [INPUT_WIDTH-1:0] value_next;
    logic [DIGIT_WIDTH-1:0] digit_reg  [NDIG];
    logic [DIGIT_WIDTH-1:0] digit_next [NDIG];
    logic [DIGIT_WIDTH:0]   dbl        [NDIG];
    logic [DIGIT_WIDTH:0]   sub        [NDIG];
    logic [NDIG-1:0]        gen;
    logic [NDIG-1:0]        prop;
    logic [NDIG-1:0]        sum;
    logic [NDIG-1:0]        carry_in;
    logic [NDIG-1:0]        carry_out;
    logic [DIGIT_WIDTH:0]   radix_x;

    assign radix_x   = {1'b0, radix};
    assign top_digit = digit_reg[NDIG-1];

    // doubling in radix r: digit i carries out when 2d+c >= r
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            dbl[i]  = {digit_reg[i], 1'b0};
            gen[i]  = (dbl[i] >= radix_x);
            prop[i] = (dbl[i] == (radix_x - 1'b1));
        end
    end

    // carry chain resolved by one adder over generate and propagate
    assign sum       = (gen | prop) + gen + NDIG'(value_reg[INPUT_WIDTH-1]);
    assign carry_in  = sum ^ (gen | prop) ^ gen;
    assign carry_out = gen | (prop & carry_in);

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            sub[i] = dbl[i] + (DIGIT_WIDTH+1)'(carry_in[i])
                     - (carry_out[i] ? radix_x : '0);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        digit_next = digit_reg;
        priority if (ctrl.load)
        begin
            value_next = value;
            for (int i = 0; i < NDIG; i++)
            begin
                digit_next[i] = '0;
            end
        end
        else if (ctrl.conv)
        begin
            value_next = value_reg << 1;
            for (int i = 0; i < NDIG; i++)
            begin
                digit_next[i] = sub[i][DIGIT_WIDTH-1:0];
            end
        end
        else if (ctrl.emit)
        begin
            // most significant digit leaves first
            digit_next[0] = '0;
            for (int i = 1; i < NDIG; i++)
            begin
                digit_next[i] = digit_reg[i-1];
            end
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        digit_reg <= digit_next;
    end

endmodule

// ----- hdl/rdd_horner.sv -----
module rdd_horner #(
    parameter int IDX_WIDTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rdd_pkg::rdd_ctrl_t                ctrl,
    input  logic [rdd_pkg::DIGIT_WIDTH-1:0]   digit,
    input  logic [IDX_WIDTH-1:0]              index,
    output logic [rdd_pkg::DIGITS_WIDTH-1:0]  acc,
    output logic [rdd_pkg::EXP_WIDTH-1:0]     top_exponent
);
    import rdd_pkg::*;

    logic [DIGITS_WIDTH-1:0] acc_reg;
    logic [DIGITS_WIDTH-1:0] acc_next;
    logic [EXP_WIDTH-1:0]    exp_reg;
    logic [EXP_WIDTH-1:0]    exp_next;
    logic                    seen_reg;
    logic                    seen_next;

    assign acc          = acc_reg;
    assign top_exponent = exp_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        exp_next  = exp_reg;
        seen_next = seen_reg;
        priority if (ctrl.load)
        begin
            acc_next  = '0;
            exp_next  = '0;
            seen_next = 1'b0;
        end
        else if (ctrl.emit)
        begin
            // acc * 10 + digit, wrapping at the field width
            acc_next = (acc_reg << 3) + (acc_reg << 1) + DIGITS_WIDTH'(digit);
            // first nonzero digit from the top fixes the exponent
            if ((digit != '0) && !seen_reg)
            begin
                exp_next  = EXP_WIDTH'(index);
                seen_next = 1'b1;
            end
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        exp_reg <= exp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

// ----- hdl/radix_digits_as_decimal.sv -----
// an accepted item passes through ST_CONV, ST_EMIT and ST_FIN, then its result is registered
// a new item is taken only in ST_IDLE, so one item is converted at a time:
//   one input bit per cycle into the radix digits, then one digit per cycle into acc*10+d
// the output register holds a finished result while the next item is taken
// reset: rst_n async active low, sequencer idle, no result pending, radix back to 8
module radix_digits_as_decimal #(
    parameter int INPUT_WIDTH = rdd_pkg::INPUT_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    rdd_value_if.sink     item,
    rdd_result_if.source  result,
    rdd_cfg_if.sink       cfg
);
    import rdd_pkg::*;

    localparam int CNT_WIDTH = $clog2(INPUT_WIDTH);
    localparam logic [CNT_WIDTH-1:0] CNT_LAST = CNT_WIDTH'(INPUT_WIDTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [CNT_WIDTH-1:0]    cnt_reg;
    logic [CNT_WIDTH-1:0]    cnt_next;
    logic [RADIX_WIDTH-1:0]  radix_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [DIGITS_WIDTH-1:0] out_digits_reg;
    logic [EXP_WIDTH-1:0]    out_exp_reg;
    logic                    out_load;
    logic                    item_xfer;
    rdd_ctrl_t               ctrl;
    logic [DIGIT_WIDTH-1:0]  top_digit;
    logic [DIGITS_WIDTH-1:0] acc;
    logic [EXP_WIDTH-1:0]    top_exp;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid             = out_valid_reg;
    assign result.digits_as_decimal = out_digits_reg;
    assign result.top_exponent      = out_exp_reg;

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    always_comb
    begin
        ctrl.load = item_xfer;
        ctrl.conv = (state_reg == ST_CONV);
        ctrl.emit = (state_reg == ST_EMIT);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_xfer)
                begin
                    state_next = ST_CONV;
                    cnt_next   = CNT_LAST;
                end
            end
            ST_CONV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = CNT_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            radix_reg     <= RADIX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                radix_reg <= cfg.radix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_digits_reg <= acc;
            out_exp_reg    <= top_exp;
        end
    end

    rdd_digit_shifter #(
        .INPUT_WIDTH (INPUT_WIDTH)
    ) u_shifter (
        .clk       (clk),
        .ctrl      (ctrl),
        .radix     (effective_radix(radix_reg)),
        .value     (item.value),
        .top_digit (top_digit)
    );

    rdd_horner #(
        .IDX_WIDTH (CNT_WIDTH)
    ) u_horner (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .digit        (top_digit),
        .index        (cnt_reg),
        .acc          (acc),
        .top_exponent (top_exp)
    );

    // an accepted item reaches the final state after both serial passes
    a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |-> ##(2*INPUT_WIDTH+1) (state_reg == ST_FIN))
        else $error("serial passes did not take the expected number of cycles");

    // a new result shows up only out of the final state
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result register loaded outside the final state");

    // digit index never leaves the digit range
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("digit counter out of range");

endmodule
